>>> hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros used by triangle_triangle_intersect
// Concurrent checks clocked on clk; the plain form is masked during reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check outside reset
`define TTI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// check that also runs during reset
`define TTI_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/tti_pkg.sv
// ---------------------------------------------------------------------------
// tti_pkg
// Widths, types and arithmetic helpers of the triangle intersection pipeline.
// ---------------------------------------------------------------------------
package tti_pkg;

  localparam int CW   = 16;          // coordinate lane width
  localparam int VW   = 3 * CW;      // packed vertex width
  localparam int DW   = CW + 1;      // coordinate difference
  localparam int NW   = 2 * DW + 1;  // cross product component
  localparam int PNW  = NW + DW;     // normal times difference
  localparam int DOTW = PNW + 2;     // plane distance, sum of three
  localparam int PSW  = 2 * NW;      // normal times cross component
  localparam int SW   = PSW + 2;     // side value, sum of three
  localparam int DENW = DOTW + 1;    // edge denominator
  localparam int VFW  = DOTW + SW + 2; // final side test value

  localparam int AL = DOTW / 2;
  localparam int AH = DOTW - AL;
  localparam int BL = SW / 2;
  localparam int BH = SW - BL;

  localparam int PIPE_D = 7;         // register stages from accept to result

  // edge endpoints of a triangle, by edge
  localparam int EDGE_A [3] = '{0, 0, 1};
  localparam int EDGE_B [3] = '{1, 2, 2};

  typedef logic [VW-1:0]         vtx_t;
  typedef logic signed [CW-1:0]  crd_t;
  typedef logic signed [DW-1:0]  dif_t;
  typedef logic signed [NW-1:0]  nrm_t;
  typedef logic signed [PNW-1:0] pn_t;
  typedef logic signed [PSW-1:0] ps_t;
  typedef logic signed [DOTW-1:0] dot_t;
  typedef logic signed [SW-1:0]  sid_t;
  typedef logic signed [DENW-1:0] den_t;
  typedef logic signed [VFW-1:0] vf_t;

  typedef logic signed [AH+BH-1:0] phh_t;
  typedef logic signed [AH+BL:0]   phl_t;
  typedef logic signed [AL+BH:0]   plh_t;
  typedef logic [AL+BL-1:0]        pll_t;

  typedef struct packed {
    phh_t hh;
    phl_t hl;
    plh_t lh;
    pll_t ll;
  } pp_t;

  function automatic crd_t lane(vtx_t v, int k);
    return $signed(v[k*CW +: CW]);
  endfunction

  function automatic dif_t dsub(crd_t a, crd_t b);
    return dif_t'(a) - dif_t'(b);
  endfunction

  // one component of a x b
  function automatic nrm_t xcomp(dif_t a1, dif_t a2, dif_t b1, dif_t b2);
    nrm_t p1;
    nrm_t p2;
    p1 = nrm_t'(a1) * nrm_t'(b2);
    p2 = nrm_t'(a2) * nrm_t'(b1);
    return p1 - p2;
  endfunction

  // split a wide product into four narrow partial products
  function automatic pp_t mul_split(dot_t a, sid_t b);
    logic signed [AH-1:0] ah;
    logic [AL-1:0]        al;
    logic signed [BH-1:0] bh;
    logic [BL-1:0]        bl;
    pp_t r;
    ah = $signed(a[DOTW-1:AL]);
    al = a[AL-1:0];
    bh = $signed(b[SW-1:BL]);
    bl = b[BL-1:0];
    r.hh = phh_t'(ah) * phh_t'(bh);
    r.hl = phl_t'(ah) * phl_t'($signed({1'b0, bl}));
    r.lh = plh_t'($signed({1'b0, al})) * plh_t'(bh);
    r.ll = pll_t'(al) * pll_t'(bl);
    return r;
  endfunction

  function automatic vf_t mul_join(pp_t p);
    vf_t s_hh;
    vf_t s_hl;
    vf_t s_lh;
    vf_t s_ll;
    s_hh = vf_t'($signed(p.hh)) <<< (AL + BL);
    s_hl = vf_t'($signed(p.hl)) <<< AL;
    s_lh = vf_t'($signed(p.lh)) <<< BL;
    s_ll = vf_t'({1'b0, p.ll});
    return s_hh + s_hl + s_lh + s_ll;
  endfunction

endpackage

>>> hdl/tti_if.sv
// ---------------------------------------------------------------------------
// tti channel interfaces
// Valid/ready channels for triangle pairs and for the hit result.
// ---------------------------------------------------------------------------
interface tti_in_if import tti_pkg::*; ();
  logic valid;
  logic ready;
  vtx_t tri_a_v0;
  vtx_t tri_a_v1;
  vtx_t tri_a_v2;
  vtx_t tri_b_v0;
  vtx_t tri_b_v1;
  vtx_t tri_b_v2;

  modport source (output valid, output tri_a_v0, output tri_a_v1, output tri_a_v2,
                  output tri_b_v0, output tri_b_v1, output tri_b_v2, input ready);
  modport sink (input valid, input tri_a_v0, input tri_a_v1, input tri_a_v2,
                input tri_b_v0, input tri_b_v1, input tri_b_v2, output ready);
endinterface

interface tti_out_if;
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, output hit, input ready);
  modport sink (input valid, input hit, output ready);
endinterface

>>> hdl/triangle_triangle_intersect.sv
// ---------------------------------------------------------------------------
// triangle_triangle_intersect: exact edge-pierces-triangle test
// Throughput: 1 item per cycle; the whole pipeline holds while out is stalled.
// Reset: synchronous active-low rst_n clears all stage valid bits.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module triangle_triangle_intersect import tti_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  tti_in_if.sink   in_tri,
  tti_out_if.source out_res
);

  // Two identical datapaths: edges of A against the plane of B, and edges
  // of B against the plane of A. Each is seven register stages deep, the
  // last stage doubles as the output register. Valid bits ride alongside in
  // vld_r; one global enable advances every stage together, so a stall at
  // the output freezes all items in place and nothing is lost or repeated.

  vtx_t ta [3];
  vtx_t tb [3];
  logic hit_ab;
  logic hit_ba;
  logic en;

  logic [PIPE_D-1:0] vld_r;
  logic [PIPE_D-1:0] vld_nxt;

  assign ta[0] = in_tri.tri_a_v0;
  assign ta[1] = in_tri.tri_a_v1;
  assign ta[2] = in_tri.tri_a_v2;
  assign tb[0] = in_tri.tri_b_v0;
  assign tb[1] = in_tri.tri_b_v1;
  assign tb[2] = in_tri.tri_b_v2;

  // advance when the output slot is empty or being drained
  assign en           = !vld_r[PIPE_D-1] || out_res.ready;
  assign in_tri.ready = en;

  // shift a bubble in when no item is offered
  assign vld_nxt = {vld_r[PIPE_D-2:0], in_tri.valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  // edges of triangle A tested against the plane of triangle B
  tti_half u_a_on_b (
    .clk   (clk),
    .en    (en),
    .tri_v (tb),
    .pt_v  (ta),
    .hit_r (hit_ab)
  );

  // edges of triangle B tested against the plane of triangle A
  tti_half u_b_on_a (
    .clk   (clk),
    .en    (en),
    .tri_v (ta),
    .pt_v  (tb),
    .hit_r (hit_ba)
  );

  assign out_res.valid = vld_r[PIPE_D-1];
  assign out_res.hit   = hit_ab | hit_ba;

  `TTI_ASSERT(a_fill, in_tri.valid && in_tri.ready |=> vld_r[0], "accepted item not tracked")
  `TTI_ASSERT(a_hold, !en |=> $stable(vld_r), "valid bits moved during stall")
  `TTI_ASSERT_RST(a_rst_clear, !rst_n |=> vld_r == '0, "valid bits not cleared by reset")

endmodule

>>> hdl/tti_half.sv
// ---------------------------------------------------------------------------
// tti_half
// Seven-stage datapath: edges of one triangle against the other's plane.
// ---------------------------------------------------------------------------
module tti_half import tti_pkg::*; (
  input  logic clk,
  input  logic en,
  input  vtx_t tri_v [3],   // triangle that gives the plane
  input  vtx_t pt_v [3],    // triangle whose edges are tested
  output logic hit_r
);

  crd_t x [3][3];
  crd_t q [3][3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int c = 0; c < 3; c++) begin
        x[i][c] = lane(tri_v[i], c);
        q[i][c] = lane(pt_v[i], c);
      end
    end
  end

  // stage 1: differences
  dif_t e1_r [3];
  dif_t e2_r [3];
  dif_t dq1_r [3][3];
  dif_t di_r [3][3][3];   // [point][triangle vertex][component]

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        e1_r[c] <= dsub(x[1][c], x[0][c]);
        e2_r[c] <= dsub(x[2][c], x[0][c]);
      end
      for (int p = 0; p < 3; p++) begin
        for (int c = 0; c < 3; c++) begin
          dq1_r[p][c] <= dsub(q[p][c], x[0][c]);
          for (int i = 0; i < 3; i++) begin
            di_r[p][i][c] <= dsub(x[i][c], q[p][c]);
          end
        end
      end
    end
  end

  // stage 2: normal and the cross products of the side test
  nrm_t n_r [3];
  dif_t dq2_r [3][3];
  nrm_t cr_r [3][3][3];   // [point][edge][component]

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        n_r[c] <= xcomp(e1_r[(c+1)%3], e1_r[(c+2)%3], e2_r[(c+1)%3], e2_r[(c+2)%3]);
      end
      dq2_r <= dq1_r;
      for (int p = 0; p < 3; p++) begin
        for (int k = 0; k < 3; k++) begin
          for (int c = 0; c < 3; c++) begin
            cr_r[p][k][c] <= xcomp(di_r[p][k][(c+1)%3], di_r[p][k][(c+2)%3],
                                   di_r[p][(k+1)%3][(c+1)%3], di_r[p][(k+1)%3][(c+2)%3]);
          end
        end
      end
    end
  end

  // stage 3: dot product terms
  pn_t pn_r [3][3];
  ps_t ps_r [3][3][3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int p = 0; p < 3; p++) begin
        for (int c = 0; c < 3; c++) begin
          pn_r[p][c] <= pn_t'(n_r[c]) * pn_t'(dq2_r[p][c]);
          for (int k = 0; k < 3; k++) begin
            ps_r[p][k][c] <= ps_t'(n_r[c]) * ps_t'(cr_r[p][k][c]);
          end
        end
      end
    end
  end

  // stage 4: plane distances and side values
  dot_t d_r [3];
  sid_t s_r [3][3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int p = 0; p < 3; p++) begin
        d_r[p] <= dot_t'(pn_r[p][0]) + dot_t'(pn_r[p][1]) + dot_t'(pn_r[p][2]);
        for (int k = 0; k < 3; k++) begin
          s_r[p][k] <= sid_t'(ps_r[p][k][0]) + sid_t'(ps_r[p][k][1])
                     + sid_t'(ps_r[p][k][2]);
        end
      end
    end
  end

  // stage 5: crossing range check and partial products
  logic ok5_nxt [3];
  logic neg5_nxt [3];
  pp_t  pa5_nxt [3][3];
  pp_t  pb5_nxt [3][3];
  logic ok5_r [3];
  logic neg5_r [3];
  pp_t  pa5_r [3][3];
  pp_t  pb5_r [3][3];

  always_comb begin
    den_t den;
    dot_t da;
    dot_t db;
    logic den_pos;
    logic da_pos;
    logic db_pos;
    for (int e = 0; e < 3; e++) begin
      da = d_r[EDGE_A[e]];
      db = d_r[EDGE_B[e]];
      den = den_t'(db) - den_t'(da);
      den_pos = !den[DENW-1] && (den != '0);
      da_pos = !da[DOTW-1] && (da != '0);
      db_pos = !db[DOTW-1] && (db != '0);
      neg5_nxt[e] = den[DENW-1];
      ok5_nxt[e] = (den_pos && !da_pos && !db[DOTW-1])
                || (den[DENW-1] && !da[DOTW-1] && !db_pos);
      for (int k = 0; k < 3; k++) begin
        pa5_nxt[e][k] = mul_split(db, s_r[EDGE_A[e]][k]);
        pb5_nxt[e][k] = mul_split(da, s_r[EDGE_B[e]][k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ok5_r  <= ok5_nxt;
      neg5_r <= neg5_nxt;
      pa5_r  <= pa5_nxt;
      pb5_r  <= pb5_nxt;
    end
  end

  // stage 6: join partial products
  logic ok6_r [3];
  logic neg6_r [3];
  vf_t  ta6_r [3][3];
  vf_t  tb6_r [3][3];

  always_ff @(posedge clk) begin
    if (en) begin
      ok6_r  <= ok5_r;
      neg6_r <= neg5_r;
      for (int e = 0; e < 3; e++) begin
        for (int k = 0; k < 3; k++) begin
          ta6_r[e][k] <= mul_join(pa5_r[e][k]);
          tb6_r[e][k] <= mul_join(pb5_r[e][k]);
        end
      end
    end
  end

  // stage 7: strict inside test and edge merge
  logic hit_nxt;

  always_comb begin
    vf_t  v;
    logic edge_hit;
    hit_nxt = 1'b0;
    for (int e = 0; e < 3; e++) begin
      edge_hit = ok6_r[e];
      for (int k = 0; k < 3; k++) begin
        v = ta6_r[e][k] - tb6_r[e][k];
        if (neg6_r[e]) begin
          edge_hit = edge_hit & v[VFW-1];
        end else begin
          edge_hit = edge_hit & !v[VFW-1] & (v != '0);
        end
      end
      hit_nxt = hit_nxt | edge_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_r <= hit_nxt;
    end
  end

endmodule
